### sv/ephemeral_id_dwell_tracker_defines.svh
// Assertion macros for the ephemeral id dwell tracker.
// Each macro takes the clock and the active-low reset explicitly.
`ifndef EPHEMERAL_ID_DWELL_TRACKER_DEFINES_SVH
`define EPHEMERAL_ID_DWELL_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define EIDT_ASSERT_SAME(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("eidt assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define EIDT_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("eidt assertion failed");
`else
`define EIDT_ASSERT_SAME(label, clk_i, rstn_i, ante, cons)
`define EIDT_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons)
`endif

`endif

### sv/eidt_pkg.sv
// Shared types and constants for the ephemeral id dwell tracker.
// No dependencies.
`default_nettype none

package eidt_pkg;

    localparam int SLOTS_DEFAULT   = 4;
    localparam int ID_BITS_DEFAULT = 64;
    localparam int PAYLOAD_BYTES   = 32;

    // An observation is only handled when its payload has this length.
    localparam logic [7:0] PAYLOAD_LEN_OK = 8'(PAYLOAD_BYTES + 1);

    localparam logic ACTION_TICK    = 1'b0;
    localparam logic ACTION_OBSERVE = 1'b1;

    localparam logic [1:0] OUTCOME_NEW       = 2'd0;
    localparam logic [1:0] OUTCOME_MATCH     = 2'd1;
    localparam logic [1:0] OUTCOME_ENCOUNTER = 2'd2;

    typedef struct packed {
        logic        action;
        logic [31:0] tick_count;
        logic [7:0]  payload_length;
        logic [63:0] eph_id;
        logic [31:0] beacon_id;
        logic [31:0] beacon_time;
    } obs_item_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [1:0]  slot;
        logic [31:0] seen_beacon_id;
        logic [31:0] seen_beacon_time;
        logic [31:0] clock_at_result;
    } res_item_t;

endpackage

`default_nettype wire

### sv/ephemeral_id_dwell_tracker.sv
// Ephemeral id dwell tracker: id table, slot scan sequencer and result register.
// Depends on eidt_pkg and ephemeral_id_dwell_tracker_defines.svh.
//
// Usage:
//   obs channel (obs_valid / obs_stall / obs): tick requests advance the
//   local clock, observation requests are looked up in the id table.
//   res channel (res_valid / res_stall / res): one result per observation
//   of the correct payload length; ticks and wrong lengths give none.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes the minimum
//   encounter time; cfg_ready is always high.
// Sequencing:
//   A tick request is done in the idle state. An observation reads the
//   slots one at a time from the table memory (a read state, then a compare
//   state per slot), then the eval state does the dwell subtract and table
//   update. obs_stall is high for the whole of that time.
// Stalls: the result register holds a finished result while res_stall is
//   high; the next request is still taken, and its own result waits in the
//   last step until the register is free.
// Reset: the table reads as all zero through per-slot valid bits, so no
//   clearing pass is needed; the clock, pointer and result valid bit are zeroed.
`default_nettype none
`include "ephemeral_id_dwell_tracker_defines.svh"

module ephemeral_id_dwell_tracker #(
    parameter int SLOTS   = eidt_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = eidt_pkg::ID_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                obs_valid,
    output logic                     obs_stall,
    input  wire eidt_pkg::obs_item_t obs,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output eidt_pkg::res_item_t      res,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [31:0]         cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_EVAL = 2'd3;

    // Table memories and their valid bits.
    logic [ID_BITS-1:0] id_mem   [SLOTS];
    logic [31:0]        time_mem [SLOTS];
    logic [SLOTS-1:0]   slot_valid_reg;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   hit_slot_reg, hit_slot_next;
    logic               hit_reg, hit_next;
    logic [31:0]        hit_time_reg, hit_time_next;
    logic [31:0]        clock_reg, clock_next;
    logic [31:0]        min_time_reg;
    logic               res_valid_reg, res_valid_next;
    eidt_pkg::res_item_t res_reg;

    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        bid_reg;
    logic [31:0]        btime_reg;

    logic [ID_BITS-1:0] id_q_reg;
    logic [31:0]        time_q_reg;
    logic               rd_valid_reg;

    logic               obs_accept;
    logic               obs_good;
    logic               res_free;
    logic               finish;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_idx;
    logic [ID_BITS-1:0] id_cur;
    logic [31:0]        time_cur;
    logic [31:0]        dwell;
    logic               encounter;
    logic [1:0]         outcome;

    assign obs_stall  = (state_reg != S_IDLE);
    assign obs_accept = obs_valid && !obs_stall;
    assign obs_good   = (obs.action == eidt_pkg::ACTION_OBSERVE)
                     && (obs.payload_length == eidt_pkg::PAYLOAD_LEN_OK);
    assign res_free   = !res_valid_reg || !res_stall;
    assign finish     = (state_reg == S_EVAL) && res_free;

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Entries never written read as zero.
    assign id_cur   = rd_valid_reg ? id_q_reg : '0;
    assign time_cur = rd_valid_reg ? time_q_reg : '0;

    // The one subtract and compare of the dwell step.
    assign dwell     = clock_reg - hit_time_reg;
    assign encounter = (dwell >= min_time_reg);

    always_comb
    begin
        if (!hit_reg)
            outcome = eidt_pkg::OUTCOME_NEW;
        else if (encounter)
            outcome = eidt_pkg::OUTCOME_ENCOUNTER;
        else
            outcome = eidt_pkg::OUTCOME_MATCH;
    end

    // A miss replaces the slot under the pointer; an encounter refreshes the hit slot.
    assign mem_we = finish && (!hit_reg || encounter);
    assign wr_idx = hit_reg ? hit_slot_reg : ptr_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        ptr_next       = ptr_reg;
        hit_slot_next  = hit_slot_reg;
        hit_next       = hit_reg;
        hit_time_next  = hit_time_reg;
        clock_next     = clock_reg;
        res_valid_next = res_valid_reg && res_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (obs_accept)
                begin
                    if (obs.action == eidt_pkg::ACTION_TICK)
                    begin
                        clock_next = clock_reg + obs.tick_count;
                    end
                    else if (obs_good)
                    begin
                        scan_idx_next = '0;
                        hit_next      = 1'b0;
                        state_next    = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // Later slots overwrite earlier matches, so the highest one wins.
                if (id_cur == id_reg)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = scan_idx_reg;
                    hit_time_next = time_cur;
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    state_next    = S_RD;
                end
            end
            S_EVAL:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (!hit_reg)
                        ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            ptr_reg        <= '0;
            hit_slot_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_time_reg   <= '0;
            clock_reg      <= '0;
            min_time_reg   <= '0;
            res_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            ptr_reg       <= ptr_next;
            hit_slot_reg  <= hit_slot_next;
            hit_reg       <= hit_next;
            hit_time_reg  <= hit_time_next;
            clock_reg     <= clock_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
                min_time_reg <= cfg_data;
            if (mem_we)
                slot_valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Request payload and result payload.
    always_ff @(posedge clk)
    begin
        if (obs_accept)
        begin
            id_reg    <= obs.eph_id[ID_BITS-1:0];
            bid_reg   <= obs.beacon_id;
            btime_reg <= obs.beacon_time;
        end
        if (finish)
        begin
            res_reg.outcome          <= outcome;
            res_reg.slot             <= 2'(hit_reg ? hit_slot_reg : ptr_reg);
            res_reg.seen_beacon_id   <= bid_reg;
            res_reg.seen_beacon_time <= btime_reg;
            res_reg.clock_at_result  <= clock_reg;
        end
    end

    // Table memories: one read port at the scan index, one write port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            id_q_reg     <= id_mem[scan_idx_reg];
            time_q_reg   <= time_mem[scan_idx_reg];
            rd_valid_reg <= slot_valid_reg[scan_idx_reg];
        end
        if (mem_we)
        begin
            id_mem[wr_idx]   <= id_reg;
            time_mem[wr_idx] <= clock_reg;
        end
    end

    `EIDT_ASSERT_NEXT(a_good_obs_scans, clk, rst_n, obs_accept && obs_good, state_reg == S_RD)
    `EIDT_ASSERT_NEXT(a_tick_adds, clk, rst_n,
        obs_accept && (obs.action == eidt_pkg::ACTION_TICK),
        clock_reg == $past(clock_reg) + $past(obs.tick_count))
    `EIDT_ASSERT_SAME(a_result_from_eval, clk, rst_n, $rose(res_valid_reg),
        $past(state_reg) == S_EVAL)
    `EIDT_ASSERT_SAME(a_scan_in_range, clk, rst_n, state_reg != S_IDLE,
        (scan_idx_reg <= LAST_IDX) && (ptr_reg <= LAST_IDX))

endmodule

`default_nettype wire

### dv/ephemeral_id_dwell_tracker_test.sv
// Self-checking testbench for the ephemeral id dwell tracker: a directed table, then random
// phases under several minimum dwell settings, checked against table rows or a predictor.
// Depends on eidt_pkg and the ephemeral_id_dwell_tracker RTL.

module ephemeral_id_dwell_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT    = eidt_pkg::SLOTS_DEFAULT;
    localparam int SETTLE_CYCLES = 2 * SLOT_COUNT + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ROW_COUNT     = 25;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [63:0] ID_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] ID_B = 64'hFEDC_BA98_7654_3210;
    localparam logic [63:0] ID_C = 64'h5A5A_A5A5_0F0F_F0F0;
    localparam logic [63:0] ID_D = 64'h8000_0000_0000_0001;

    typedef struct {
        logic                cfg_write;
        logic [31:0]         cfg_value;
        eidt_pkg::obs_item_t item;
        logic                typed;
        eidt_pkg::res_item_t want;
    } step_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                obs_valid = 1'b0;
    logic                obs_stall;
    eidt_pkg::obs_item_t obs       = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    eidt_pkg::res_item_t res;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [31:0]         cfg_data  = '0;

    // Predictor state
    logic [63:0]         tracked_id [SLOT_COUNT];
    logic [31:0]         stamped_at [SLOT_COUNT];
    int                  victim_slot;
    logic [31:0]         local_clock;
    logic [31:0]         min_dwell;
    eidt_pkg::res_item_t awaited[$];

    logic                produced_result;
    eidt_pkg::res_item_t predicted_result;
    logic                typed_next = 1'b0;
    eidt_pkg::res_item_t typed_want = '0;

    int                  mismatches = 0;
    int                  cycles     = 0;
    int                  stall_pct  = 25;
    int                  stall_left = 0;
    logic                stall_run  = 1'b0;
    int                  tick_span  = 40;
    logic [63:0]         id_pool [6];

    ephemeral_id_dwell_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .obs_valid (obs_valid),
        .obs_stall (obs_stall),
        .obs       (obs),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ephemeral_id_dwell_tracker_test failed");
            $finish;
        end
    end

    // The receiver stalls in runs of random length, so that both long holds and
    // back-to-back acceptance occur.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(1, 8);
            stall_run  = ($urandom_range(99) < stall_pct);
        end
        stall_left--;
        res_stall <= stall_run;
    end

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    task automatic track_request(input eidt_pkg::obs_item_t it, output logic produced,
                                 output eidt_pkg::res_item_t r);
        int          hit_at;
        int          k;
        logic [31:0] dwell;
        produced = 1'b0;
        r        = '0;
        hit_at   = -1;
        if (it.action == eidt_pkg::ACTION_TICK)
        begin
            local_clock = local_clock + it.tick_count;
        end
        else if (it.payload_length == eidt_pkg::PAYLOAD_LEN_OK)
        begin
            // The last matching slot found is the highest-numbered one.
            for (k = 0; k < SLOT_COUNT; k++)
                if (tracked_id[k] == it.eph_id)
                    hit_at = k;
            if (hit_at < 0)
            begin
                hit_at              = victim_slot;
                victim_slot         = (victim_slot + 1) % SLOT_COUNT;
                tracked_id[hit_at]  = it.eph_id;
                stamped_at[hit_at]  = local_clock;
                r.outcome           = eidt_pkg::OUTCOME_NEW;
            end
            else
            begin
                dwell = local_clock - stamped_at[hit_at];
                if (dwell >= min_dwell)
                begin
                    stamped_at[hit_at] = local_clock;
                    r.outcome          = eidt_pkg::OUTCOME_ENCOUNTER;
                end
                else
                begin
                    r.outcome = eidt_pkg::OUTCOME_MATCH;
                end
            end
            produced           = 1'b1;
            r.slot             = 2'(hit_at);
            r.seen_beacon_id   = it.beacon_id;
            r.seen_beacon_time = it.beacon_time;
            r.clock_at_result  = local_clock;
        end
    endtask

    task automatic check_result(input eidt_pkg::res_item_t got);
        eidt_pkg::res_item_t want;
        if (awaited.size() == 0)
        begin
            report_mismatch("result with nothing outstanding, clock", 64'd0,
                            64'(got.clock_at_result));
        end
        else
        begin
            want = awaited.pop_front();
            if (got.outcome != want.outcome)
                report_mismatch("outcome", 64'(want.outcome), 64'(got.outcome));
            if (got.slot != want.slot)
                report_mismatch("slot", 64'(want.slot), 64'(got.slot));
            if (got.seen_beacon_id != want.seen_beacon_id)
                report_mismatch("seen_beacon_id", 64'(want.seen_beacon_id),
                                64'(got.seen_beacon_id));
            if (got.seen_beacon_time != want.seen_beacon_time)
                report_mismatch("seen_beacon_time", 64'(want.seen_beacon_time),
                                64'(got.seen_beacon_time));
            if (got.clock_at_result != want.clock_at_result)
                report_mismatch("clock_at_result", 64'(want.clock_at_result),
                                64'(got.clock_at_result));
        end
    endtask

    // Results are checked before the request accepted at the same edge is predicted,
    // so a result can never be matched against its own request's expectation early.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                tracked_id[k] = '0;
                stamped_at[k] = '0;
            end
            victim_slot = 0;
            local_clock = '0;
            min_dwell   = '0;
            awaited.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res);
            if (obs_valid && !obs_stall)
            begin
                track_request(obs, produced_result, predicted_result);
                if (typed_next)
                    awaited.push_back(typed_want);
                else if (produced_result)
                    awaited.push_back(predicted_result);
            end
            if (cfg_valid && cfg_ready)
                min_dwell = cfg_data;
        end
    end

    task automatic send_request(input eidt_pkg::obs_item_t it, input logic typed,
                                input eidt_pkg::res_item_t want);
        @(negedge clk);
        obs_valid  = 1'b1;
        obs        = it;
        typed_next = typed;
        typed_want = want;
        do
            @(posedge clk);
        while (obs_stall);
    endtask

    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            obs_valid  = 1'b0;
            typed_next = 1'b0;
            obs.eph_id = {$urandom, $urandom};
        end
    endtask

    task automatic wait_results();
        hold_off(1);
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    // A dropped request or a tick may still be in flight after the last result.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_dwell(input logic [31:0] value);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = $urandom;
    endtask

    function automatic step_row_t tick_row(input logic [31:0] n);
        step_row_t r;
        r.cfg_write = 1'b0;
        r.cfg_value = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        r.item      = '{eidt_pkg::ACTION_TICK, n, 8'($urandom), {$urandom, $urandom},
                        $urandom, $urandom};
        return r;
    endfunction

    function automatic step_row_t obs_row(input logic [63:0] id, input logic [7:0] len,
                                          input logic [31:0] bid, input logic [31:0] btime);
        step_row_t r;
        r.cfg_write = 1'b0;
        r.cfg_value = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        r.item      = '{eidt_pkg::ACTION_OBSERVE, $urandom, len, id, bid, btime};
        return r;
    endfunction

    function automatic step_row_t seen(input step_row_t row, input logic [1:0] outcome,
                                       input logic [1:0] slot, input logic [31:0] at_clock);
        step_row_t r;
        r       = row;
        r.typed = 1'b1;
        r.want  = '{outcome, slot, row.item.beacon_id, row.item.beacon_time, at_clock};
        return r;
    endfunction

    function automatic step_row_t cfg_row(input logic [31:0] value);
        step_row_t r;
        r.cfg_write = 1'b1;
        r.cfg_value = value;
        r.item      = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic eidt_pkg::obs_item_t random_request();
        eidt_pkg::obs_item_t it;
        int                  pick;
        it.action         = ($urandom_range(99) < 35) ? eidt_pkg::ACTION_TICK
                                                      : eidt_pkg::ACTION_OBSERVE;
        it.tick_count     = ($urandom_range(99) < 20) ? $urandom : $urandom_range(tick_span);
        it.payload_length = ($urandom_range(99) < 88) ? eidt_pkg::PAYLOAD_LEN_OK
                                                      : 8'($urandom);
        pick = $urandom_range(9);
        if (pick < 6)
            it.eph_id = id_pool[pick];
        else if (pick < 8)
            it.eph_id = {$urandom, $urandom};
        else if (pick == 8)
            it.eph_id = '0;
        else
            it.eph_id = '1;
        it.beacon_id   = $urandom;
        it.beacon_time = $urandom;
        return it;
    endfunction

    // Ids come mostly from a pool a little larger than the table, so that hits,
    // dwell checks and round-robin evictions all occur often.
    task automatic run_phase(input logic [31:0] dwell, input int count, input int span,
                             input int gap_max, input int stall);
        eidt_pkg::obs_item_t it;
        int                  sent;
        int                  since_pause;
        int                  p;
        write_min_dwell(dwell);
        tick_span   = span;
        stall_pct   = stall;
        sent        = 0;
        since_pause = 0;
        for (p = 0; p < 6; p++)
            id_pool[p] = {$urandom, $urandom};
        while (sent < count)
        begin
            repeat ($urandom_range(1, 12))
            begin
                it = random_request();
                send_request(it, 1'b0, '0);
                if (it.action == eidt_pkg::ACTION_TICK
                    || it.payload_length == eidt_pkg::PAYLOAD_LEN_OK)
                    sent++;
                since_pause++;
                if (since_pause == 150)
                begin
                    wait_results();
                    since_pause = 0;
                end
            end
            if (gap_max > 0)
                hold_off($urandom_range(0, gap_max));
        end
    endtask

    initial
    begin : main
        step_row_t rows [ROW_COUNT];
        rows = '{
            // The cleared table matches an all-zero id, and the top slot wins.
            seen(obs_row('0, eidt_pkg::PAYLOAD_LEN_OK, '0, '0),
                 eidt_pkg::OUTCOME_ENCOUNTER, 2'd3, 32'd0),
            tick_row(32'hFFFF_FFFF),
            seen(obs_row('1, eidt_pkg::PAYLOAD_LEN_OK, '1, '1),
                 eidt_pkg::OUTCOME_NEW, 2'd0, 32'hFFFF_FFFF),
            tick_row(32'd1),
            seen(obs_row('1, eidt_pkg::PAYLOAD_LEN_OK, 32'h1234_5678, 32'h9ABC_DEF0),
                 eidt_pkg::OUTCOME_ENCOUNTER, 2'd0, 32'd0),
            obs_row('0, eidt_pkg::PAYLOAD_LEN_OK - 8'd1, $urandom, $urandom),
            obs_row('0, eidt_pkg::PAYLOAD_LEN_OK + 8'd1, $urandom, $urandom),
            obs_row('0, 8'h00, $urandom, $urandom),
            obs_row('0, 8'hFF, $urandom, $urandom),
            seen(obs_row('0, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
                 eidt_pkg::OUTCOME_ENCOUNTER, 2'd3, 32'd0),
            obs_row(ID_A, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
            obs_row(ID_B, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
            obs_row(ID_C, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
            obs_row(ID_D, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
            cfg_row(32'd100),
            tick_row(32'd50),
            seen(obs_row(ID_A, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
                 eidt_pkg::OUTCOME_MATCH, 2'd1, 32'd50),
            tick_row(32'd50),
            seen(obs_row(ID_A, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
                 eidt_pkg::OUTCOME_ENCOUNTER, 2'd1, 32'd100),
            cfg_row(32'hFFFF_FFFF),
            seen(obs_row(ID_B, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
                 eidt_pkg::OUTCOME_MATCH, 2'd2, 32'd100),
            // Brings the dwell of the second id to the largest value the clock allows.
            tick_row(32'hFFFF_FF9B),
            seen(obs_row(ID_B, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
                 eidt_pkg::OUTCOME_ENCOUNTER, 2'd2, 32'hFFFF_FFFF),
            obs_row(ID_C, eidt_pkg::PAYLOAD_LEN_OK, $urandom, $urandom),
            cfg_row(32'd0)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].cfg_write)
                write_min_dwell(rows[i].cfg_value);
            else
                send_request(rows[i].item, rows[i].typed, rows[i].want);
            hold_off($urandom_range(0, 2));
        end

        run_phase(32'd0, 200, 40, 6, 30);
        run_phase(32'($urandom_range(1, 60)), 200, 40, 4, 50);
        run_phase(32'hFFFF_FFFF, 150, 40, 3, 20);
        run_phase($urandom, 150, 40, 6, 70);
        run_phase(32'd20, 150, 30, 0, 0);
        run_phase(32'h8000_0000, 150, 40, 5, 40);

        settle();
        if (mismatches == 0 && awaited.size() == 0)
            $display("ephemeral_id_dwell_tracker_test passed");
        else
            $display("ephemeral_id_dwell_tracker_test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/eidt_pkg.sv
sv/ephemeral_id_dwell_tracker.sv
dv/ephemeral_id_dwell_tracker_test.sv
